// ===== hw/rtl/lpft_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared types and constants for the LRU page frame table.
// ----------------------------------------------------------------------------
package lpft_pkg;

  localparam int FRAMES     = 16;
  localparam int FRAME_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCNT_W     = $clog2(FRAMES + 1);
  localparam int PAGE_BITS  = 16;
  localparam int IN_PAGE_W  = 16;
  localparam int STAMP_W    = 32;
  localparam int FIU_W      = 5;
  localparam int LIMIT_W    = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int ENTRY_W    = PAGE_BITS + STAMP_W;

  localparam int FIU_RESET   = 16;
  localparam int LIMIT_RESET = 65536;

  typedef logic [FRAME_W-1:0]   frame_t;
  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IN_PAGE_W-1:0] io_page_t;
  typedef logic [STAMP_W-1:0]   stamp_t;
  typedef logic [LIMIT_W-1:0]   limit_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAMES_IN_USE,
    CFG_PAGE_LIMIT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OUT_HIT,
    OUT_LOAD,
    OUT_EVICT,
    OUT_REJECT
  } outcome_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    frame_t last;
    limit_t limit;
  } cfg_t;

  typedef struct packed {
    outcome_t outcome;
    frame_t   frame;
    io_page_t evicted;
    stamp_t   stamp;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lpft_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpft_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpft_ram #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int DATA_W = 48
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lpft_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpft_scan
// Frame scan engine: one frame entry read per cycle, hit/free/oldest search,
// single write-back of the chosen frame.
// ----------------------------------------------------------------------------
module lpft_scan (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire lpft_pkg::io_page_t page_in,
  input  wire lpft_pkg::cfg_t     cfg,
  output logic                    res_strobe,
  output lpft_pkg::result_t       res
);

  lpft_pkg::state_t   state_r, state_nxt;
  logic [lpft_pkg::FCNT_W-1:0] rd_idx_r;
  logic               eval_v_r;
  lpft_pkg::frame_t   eval_idx_r;
  lpft_pkg::frame_t   best_idx_r;
  lpft_pkg::stamp_t   best_stamp_r;
  lpft_pkg::page_t    best_page_r;
  logic [lpft_pkg::FRAMES-1:0] valid_r;
  lpft_pkg::stamp_t   counter_r;
  lpft_pkg::page_t    page_r;
  logic               strobe_r;
  lpft_pkg::result_t  res_r;

  lpft_pkg::page_t    page_in_m;
  logic               reject;
  logic               accept;
  logic               issue;
  logic               ram_we;
  lpft_pkg::frame_t   rd_addr;
  logic [lpft_pkg::ENTRY_W-1:0] rdata;
  lpft_pkg::page_t    rd_page;
  lpft_pkg::stamp_t   rd_stamp;
  logic               cur_valid;
  logic               hit;
  logic               free;
  logic               found;
  logic               at_last;
  logic               take_cur;
  logic               done;
  lpft_pkg::frame_t   frame_sel;
  lpft_pkg::page_t    evict_page;
  lpft_pkg::outcome_t outcome_sel;

  assign page_in_m = lpft_pkg::page_t'(page_in);
  assign reject    = lpft_pkg::limit_t'(page_in_m) >= cfg.limit;
  assign rd_page   = rdata[lpft_pkg::ENTRY_W-1:lpft_pkg::STAMP_W];
  assign rd_stamp  = rdata[lpft_pkg::STAMP_W-1:0];
  assign cur_valid = valid_r[eval_idx_r];
  assign hit       = cur_valid && (rd_page == page_r);
  assign free      = !cur_valid;
  assign found     = hit || free;
  assign at_last   = (eval_idx_r == cfg.last);
  assign take_cur  = (eval_idx_r == '0) || (rd_stamp < best_stamp_r);
  assign done      = (state_r == lpft_pkg::ST_SCAN) && eval_v_r && (found || at_last);

  always_comb begin
    if (found) begin
      frame_sel   = eval_idx_r;
      evict_page  = '0;
      outcome_sel = hit ? lpft_pkg::OUT_HIT : lpft_pkg::OUT_LOAD;
    end else begin
      frame_sel   = take_cur ? eval_idx_r : best_idx_r;
      evict_page  = take_cur ? rd_page : best_page_r;
      outcome_sel = lpft_pkg::OUT_EVICT;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpft_pkg::ST_IDLE: begin
        if (start && !reject) begin
          state_nxt = lpft_pkg::ST_SCAN;
        end
      end
      lpft_pkg::ST_SCAN: begin
        if (done) begin
          state_nxt = lpft_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpft_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy    = 1'b0;
    accept  = 1'b0;
    issue   = 1'b0;
    ram_we  = 1'b0;
    rd_addr = rd_idx_r[lpft_pkg::FRAME_W-1:0];
    case (state_r)
      lpft_pkg::ST_IDLE: begin
        accept = start;
      end
      lpft_pkg::ST_SCAN: begin
        busy   = 1'b1;
        issue  = rd_idx_r <= lpft_pkg::FCNT_W'(cfg.last);
        ram_we = done;
      end
      default: busy = 1'b1;
    endcase
  end

  lpft_ram #(
    .DEPTH  (lpft_pkg::FRAMES),
    .ADDR_W (lpft_pkg::FRAME_W),
    .DATA_W (lpft_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (frame_sel),
    .wdata ({page_r, counter_r}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lpft_pkg::ST_IDLE;
      rd_idx_r  <= '0;
      eval_v_r  <= 1'b0;
      valid_r   <= '0;
      counter_r <= '0;
      strobe_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      eval_v_r <= issue && !done;
      strobe_r <= (accept && reject) || done;
      if (accept) begin
        rd_idx_r <= '0;
      end else if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (done) begin
        valid_r[frame_sel] <= 1'b1;
        counter_r          <= counter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= rd_addr;
    if (accept) begin
      page_r <= page_in_m;
    end
    if (eval_v_r && take_cur) begin
      best_idx_r   <= eval_idx_r;
      best_stamp_r <= rd_stamp;
      best_page_r  <= rd_page;
    end
    if (accept && reject) begin
      res_r.outcome <= lpft_pkg::OUT_REJECT;
      res_r.frame   <= '0;
      res_r.evicted <= '0;
      res_r.stamp   <= counter_r;
    end else if (done) begin
      res_r.outcome <= outcome_sel;
      res_r.frame   <= frame_sel;
      res_r.evicted <= lpft_pkg::io_page_t'(evict_page);
      res_r.stamp   <= counter_r;
    end
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

  a_eval_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    eval_v_r |-> state_r == lpft_pkg::ST_SCAN)
    else $error("entry evaluated outside a scan");

  a_done_marks: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> strobe_r && valid_r[$past(frame_sel)])
    else $error("write-back without result or valid mark");

  a_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !done |=> counter_r == $past(counter_r))
    else $error("access counter moved without a write-back");

  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> frame_sel <= cfg.last)
    else $error("write-back beyond active frames");

  a_fresh_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !eval_v_r)
    else $error("stale entry evaluated at scan start");

endmodule
`default_nettype wire

// ===== hw/rtl/lru_page_frame_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_frame_table
// Inverted page table with LRU replacement over up to 16 physical frames.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with in_page_number while busy is low; the item is taken at
//   that edge. Exactly one result follows on the out_ ports, marked by a
//   one-cycle out_strobe; the receiver must take it in that cycle.
//   A rejected page (at or above the page limit) returns its result in the
//   next cycle and never raises busy.
//   Any other access scans frames 0 upward, one frame entry per cycle through
//   the single read port of the frame memory. It stops at the first hit or free
//   frame; with every active frame full it ends at the last one and evicts the
//   frame with the oldest stamp (the lowest index on a tie).
//   busy drops with the result, so the next item can be taken the cycle the
//   result appears.
//   cfg_we/cfg_index/cfg_wdata write frames_in_use (0) or the page limit (1);
//   write only while no item is pending.
//   Reset (rst_n low, synchronous) marks every frame free, zeroes the access
//   counter and restores 16 frames and a page limit of 65536.
// ----------------------------------------------------------------------------
module lru_page_frame_table (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [lpft_pkg::IN_PAGE_W-1:0]     in_page_number,
  output logic                                    out_strobe,
  output logic [1:0]                              out_outcome,
  output logic [lpft_pkg::FRAME_W-1:0]            out_frame_index,
  output logic [lpft_pkg::IN_PAGE_W-1:0]          out_evicted_page,
  output logic [lpft_pkg::STAMP_W-1:0]            out_stamp,
  input  wire logic                               cfg_we,
  input  wire logic [lpft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lpft_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [lpft_pkg::FIU_W-1:0] fiu_r;
  lpft_pkg::limit_t           limit_r;
  lpft_pkg::cfg_t             cfg;
  lpft_pkg::result_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fiu_r   <= lpft_pkg::FIU_W'(lpft_pkg::FIU_RESET);
      limit_r <= lpft_pkg::LIMIT_W'(lpft_pkg::LIMIT_RESET);
    end else if (cfg_we) begin
      case (lpft_pkg::cfg_idx_t'(cfg_index))
        lpft_pkg::CFG_FRAMES_IN_USE: fiu_r   <= cfg_wdata[lpft_pkg::FIU_W-1:0];
        lpft_pkg::CFG_PAGE_LIMIT:    limit_r <= cfg_wdata[lpft_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame count to 1..FRAMES, kept as index of the last active frame
  always_comb begin
    cfg.limit = limit_r;
    if (fiu_r == '0) begin
      cfg.last = '0;
    end else if (32'(fiu_r) > lpft_pkg::FRAMES) begin
      cfg.last = lpft_pkg::FRAME_W'(lpft_pkg::FRAMES - 1);
    end else begin
      cfg.last = lpft_pkg::FRAME_W'(fiu_r - 1'b1);
    end
  end

  lpft_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .page_in    (in_page_number),
    .cfg        (cfg),
    .res_strobe (out_strobe),
    .res        (res)
  );

  assign out_outcome      = res.outcome;
  assign out_frame_index  = res.frame;
  assign out_evicted_page = res.evicted;
  assign out_stamp        = res.stamp;

endmodule
`default_nettype wire
